FILE: hdl/twspi_pkg.sv
// ----------------------------------------------------------------------------
// twspi_pkg
// Types and constants shared by the three-wire serial register master.
// ----------------------------------------------------------------------------
package twspi_pkg;

    // Instruction word and tick plan
    localparam logic [15:0] READ_FLAG       = 16'h8000;
    localparam logic [5:0]  WRITE_LAST      = 6'd50;
    localparam logic [5:0]  READ_LAST       = 6'd51;
    localparam logic [5:0]  READ_DATA_FIRST = 6'd35;
    localparam logic [5:0]  TURN_FIRST      = 6'd33;
    localparam logic [5:0]  WRITE_BIT_TICKS = 6'd48;
    localparam logic [5:0]  READ_BIT_TICKS  = 6'd32;
    localparam logic [4:0]  WORD_MSB        = 5'd23;
    localparam logic [2:0]  BYTE_MSB        = 3'd7;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // One tick of input
    typedef struct packed {
        logic        start_req;
        logic        operation;
        logic [12:0] reg_address;
        logic [7:0]  write_data;
        logic        sdio_in;
    } tick_in_t;

    // One tick of line levels and status
    typedef struct packed {
        logic       sclk_level;
        logic       sdio_out;
        logic       sdio_drive;
        logic       chip_select_n;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } tick_out_t;

endpackage

FILE: hdl/twspi_if.sv
// ----------------------------------------------------------------------------
// twspi_in_if / twspi_out_if
// Valid/ready channels carrying tick requests and tick results.
// ----------------------------------------------------------------------------
interface twspi_in_if;
    logic                valid;
    logic                ready;
    twspi_pkg::tick_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface twspi_out_if;
    logic                 valid;
    logic                 ready;
    twspi_pkg::tick_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/three_wire_spi_register_master_core.sv
// ----------------------------------------------------------------------------
// three_wire_spi_register_master_core
// Three-wire serial register master, one half-bit tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per half-bit tick: start, operation, address,
//   write byte and the sampled data line level. out_ch returns one result per
//   request: clock level, data level and drive enable, chip select, busy,
//   done and the last read byte.
//   A write runs 51 ticks, a read 52; a start while busy is ignored.
//   The result appears in the cycle after the request is taken.
//   Throughput: one request per cycle unless stalled; the tick decode is a
//   single pass from state registers and request into the output register.
//   Stall: the output register holds its result while out_ch.ready is low,
//   and a new request is still taken in the cycle the result is taken.
//   Reset: the bus returns to idle (chip select high, clock low) and the
//   read byte clears to zero; no result is pending.
// ----------------------------------------------------------------------------
module three_wire_spi_register_master_core #(
    parameter int ADDRESS_WIDTH = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    twspi_in_if.sink    in_ch,
    twspi_out_if.source out_ch
);
    import twspi_pkg::*;

    logic      step;
    tick_out_t tick_result;
    tick_out_t out_data_reg;
    logic      out_valid_reg;

    // Take a request whenever the output slot is free or being emptied
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    twspi_tick #(
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_tick (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_ch.data),
        .result(tick_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= tick_result;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

FILE: hdl/twspi_tick.sv
// ----------------------------------------------------------------------------
// twspi_tick
// Transaction state and the per-tick line decode; state advances on step.
// ----------------------------------------------------------------------------
module twspi_tick #(
    parameter int ADDRESS_WIDTH = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  twspi_pkg::tick_in_t  item,
    output twspi_pkg::tick_out_t result
);
    import twspi_pkg::*;

    localparam logic [12:0] ADDR_MASK = 13'((1 << ADDRESS_WIDTH) - 1);

    logic [5:0]  phase_count_reg, phase_count_next;
    logic [23:0] shift_word_reg,  shift_word_next;
    logic        is_read_reg,     is_read_next;
    logic [7:0]  captured_byte_reg, captured_byte_next;
    logic        active_reg,      active_next;

    logic        start_go;
    logic        cur_read;
    logic [23:0] cur_word;
    logic [23:0] load_word;
    logic [15:0] instr;
    logic [5:0]  t;
    logic [5:0]  t_bit;
    logic [5:0]  t_rd;
    logic [5:0]  last;
    logic [5:0]  bit_ticks;
    logic [4:0]  k_out;
    logic [2:0]  k_in;
    logic        is_last;

    // Start decode and instruction load
    always_comb
    begin
        start_go  = !active_reg && item.start_req;
        instr     = {3'b000, item.reg_address & ADDR_MASK};
        if (item.operation == OP_READ)
        begin
            instr = instr | READ_FLAG;
        end
        load_word = (item.operation == OP_READ) ? {instr, 8'h00}
                                                : {instr, item.write_data};
        cur_read  = start_go ? item.operation : is_read_reg;
        cur_word  = start_go ? load_word : shift_word_reg;
        t         = start_go ? 6'd0 : phase_count_reg;
        last      = (cur_read == OP_READ) ? READ_LAST : WRITE_LAST;
        bit_ticks = (cur_read == OP_READ) ? READ_BIT_TICKS : WRITE_BIT_TICKS;
        t_bit     = t - 6'd1;
        t_rd      = t - READ_DATA_FIRST;
        k_out     = t_bit[5:1];
        k_in      = t_rd[3:1];
        is_last   = (t >= last);
    end

    // Line levels and next state for this tick
    always_comb
    begin
        result             = '0;
        result.sdio_drive  = 1'b1;
        result.chip_select_n = 1'b1;
        result.read_data   = captured_byte_reg;
        phase_count_next   = phase_count_reg;
        shift_word_next    = cur_word;
        is_read_next       = cur_read;
        captured_byte_next = captured_byte_reg;
        active_next        = active_reg;

        if (active_reg || start_go)
        begin
            result.busy_res      = 1'b1;
            result.chip_select_n = 1'b0;
            // setup and closing ticks fall through both arms
            if (t >= 6'd1 && t <= bit_ticks)
            begin
                result.sclk_level = t_bit[0];
                result.sdio_out   = cur_word[WORD_MSB - k_out];
            end
            else if (cur_read == OP_READ && t >= TURN_FIRST && t < READ_LAST)
            begin
                result.sdio_drive = 1'b0;
                if (t >= READ_DATA_FIRST)
                begin
                    result.sclk_level = t_rd[0];
                    if (!t_rd[0] && item.sdio_in)
                    begin
                        shift_word_next[BYTE_MSB - k_in] = 1'b1;
                    end
                end
            end

            if (is_last)
            begin
                result.chip_select_n = 1'b1;
                result.sdio_drive    = 1'b1;
                result.done_res      = 1'b1;
                if (cur_read == OP_READ)
                begin
                    captured_byte_next = shift_word_next[7:0];
                    result.read_data   = shift_word_next[7:0];
                end
                active_next      = 1'b0;
                phase_count_next = 6'd0;
            end
            else
            begin
                active_next      = 1'b1;
                phase_count_next = t + 6'd1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg   <= '0;
            shift_word_reg    <= '0;
            is_read_reg       <= 1'b0;
            captured_byte_reg <= '0;
            active_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_count_reg   <= phase_count_next;
            shift_word_reg    <= shift_word_next;
            is_read_reg       <= is_read_next;
            captured_byte_reg <= captured_byte_next;
            active_reg        <= active_next;
        end
    end

endmodule

FILE: hdl/twspi_core_checker.sv
// ----------------------------------------------------------------------------
// twspi_core_checker
// Port-level checks on the serial register master, bound to the top level.
// ----------------------------------------------------------------------------
module twspi_core_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input twspi_pkg::tick_out_t out_data
);
    import twspi_pkg::*;

    // A stalled result stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // Every request taken yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("request produced no result");

    // The done tick releases chip select and drives the line again
    a_done_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |->
            out_data.busy_res && out_data.chip_select_n && out_data.sdio_drive
            && !out_data.sclk_level)
        else $error("bad line levels on done tick");

    // Idle bus levels
    a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res |->
            out_data.chip_select_n && !out_data.sclk_level && out_data.sdio_drive
            && !out_data.sdio_out && !out_data.done_res)
        else $error("bad idle bus levels");

endmodule

bind three_wire_spi_register_master_core twspi_core_checker u_twspi_core_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_ch.data)
);

FILE: dv/twspi_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twspi_tb_pkg
// Line-level predictor and result checker for the three-wire register master.
// Every accepted request is turned into the expected line levels and status
// for that tick. Each returned result is compared field by field, in order.
// ----------------------------------------------------------------------------
package twspi_tb_pkg;
    import twspi_pkg::*;

    localparam int ADDR_W = 13;

    class spi_tick_scoreboard;
        // Predicted bus master state
        bit [5:0]  tick_no;
        bit [23:0] shift_reg;
        bit        rd_mode;
        bit        running;
        bit [7:0]  rd_byte;

        tick_out_t expected_ticks[$];

        int errors;
        int checked;
        int writes_started;
        int reads_started;
        int starts_ignored;

        // Advance the predicted master by one half-bit tick
        function tick_out_t predict_tick(tick_in_t rq);
            tick_out_t   res;
            bit [15:0]   instr;
            int unsigned t;
            int unsigned k;
            int unsigned last_tick;
            int unsigned bit_ticks;

            res = '0;
            res.sdio_drive    = 1'b1;
            res.chip_select_n = 1'b1;

            // Start is only taken while idle
            if (rq.start_req)
            begin
                if (running)
                begin
                    starts_ignored++;
                end
                else
                begin
                    rd_mode = (rq.operation == OP_READ);
                    instr = '0;
                    instr[12:0] = rq.reg_address & 13'((1 << ADDR_W) - 1);
                    if (rd_mode)
                    begin
                        instr = instr | READ_FLAG;
                        reads_started++;
                    end
                    else
                    begin
                        writes_started++;
                    end
                    shift_reg = {instr, rd_mode ? 8'h00 : rq.write_data};
                    tick_no = '0;
                    running = 1'b1;
                end
            end

            if (running)
            begin
                t = tick_no;
                last_tick = rd_mode ? READ_LAST : WRITE_LAST;
                bit_ticks = rd_mode ? READ_BIT_TICKS : WRITE_BIT_TICKS;
                res.busy_res = 1'b1;
                res.chip_select_n = 1'b0;

                // Outgoing bits: low half then high half of each clock
                if (t >= 1 && t <= bit_ticks)
                begin
                    k = (t - 1) >> 1;
                    res.sclk_level = 1'((t - 1) & 1);
                    res.sdio_out   = shift_reg[WORD_MSB - k];
                end
                // Turnaround and incoming bits, line released
                else if (rd_mode && t >= TURN_FIRST && t < READ_LAST)
                begin
                    res.sdio_drive = 1'b0;
                    if (t >= READ_DATA_FIRST)
                    begin
                        k = (t - READ_DATA_FIRST) >> 1;
                        res.sclk_level = 1'((t - READ_DATA_FIRST) & 1);
                        if (!res.sclk_level && rq.sdio_in)
                            shift_reg[BYTE_MSB - k] = 1'b1;
                    end
                end

                // Closing tick
                if (t >= last_tick)
                begin
                    res.chip_select_n = 1'b1;
                    res.sdio_drive = 1'b1;
                    res.done_res = 1'b1;
                    if (rd_mode)
                        rd_byte = shift_reg[7:0];
                    running = 1'b0;
                    tick_no = '0;
                end
                else
                begin
                    tick_no = 6'(t + 1);
                end
            end

            res.read_data = rd_byte;
            return res;
        endfunction

        function void note_request(tick_in_t rq);
            expected_ticks.push_back(predict_tick(rq));
        endfunction

        function void diff(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(tick_out_t got);
            tick_out_t want;

            if (expected_ticks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = expected_ticks.pop_front();
            checked++;
            diff("sclk_level",    want.sclk_level,    got.sclk_level);
            diff("sdio_out",      want.sdio_out,      got.sdio_out);
            diff("sdio_drive",    want.sdio_drive,    got.sdio_drive);
            diff("chip_select_n", want.chip_select_n, got.chip_select_n);
            diff("busy_res",      want.busy_res,      got.busy_res);
            diff("done_res",      want.done_res,      got.done_res);
            diff("read_data",     want.read_data,     got.read_data);
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

endpackage

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for three_wire_spi_register_master_core.
// Drives half-bit tick requests (directed transfers, then random transfers
// with noise) under several idling mixes and one long output hold, and
// checks every result against the line-level predictor.
// ----------------------------------------------------------------------------
module tb;
    import twspi_pkg::*;
    import twspi_tb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_TICKS  = 100;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    twspi_in_if  in_ch();
    twspi_out_if out_ch();

    three_wire_spi_register_master_core #(.ADDRESS_WIDTH(ADDR_W)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    spi_tick_scoreboard sb;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int ticks_sent;

    always #6 clk = ~clk;

    // Result sink, request monitor and output stall control
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            // check before noting, so a result never meets its own request
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.data);

            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (hold_left == 0 && hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Offer one request, with a random gap first, and wait for it to be taken
    task automatic push_tick(input tick_in_t rq);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= rq;
        do
            @(posedge clk);
        while (!in_ch.ready);
        ticks_sent++;
    endtask

    function automatic tick_in_t noise_tick(input logic start);
        tick_in_t rq;
        rq.start_req   = start;
        rq.operation   = 1'($urandom_range(1));
        rq.reg_address = 13'($urandom_range(8191));
        rq.write_data  = 8'($urandom_range(255));
        rq.sdio_in     = 1'($urandom_range(1));
        return rq;
    endfunction

    task automatic run_idle(input int n);
        for (int i = 0; i < n; i++)
            push_tick(noise_tick(1'b0));
    endtask

    // One whole transfer; later ticks carry random starts that must be ignored
    task automatic run_transfer(input logic op, input logic [12:0] addr,
                                input logic [7:0] wdata, input line_mode_t line_mode);
        tick_in_t rq;
        int       n_ticks;

        n_ticks = (op == OP_READ) ? int'(READ_LAST) + 1 : int'(WRITE_LAST) + 1;
        for (int i = 0; i < n_ticks; i++)
        begin
            rq = noise_tick((i == 0) ? 1'b1 : 1'($urandom_range(1)));
            if (i == 0)
            begin
                rq.operation   = op;
                rq.reg_address = addr;
                rq.write_data  = wdata;
            end
            if (line_mode != LINE_RANDOM)
                rq.sdio_in = (line_mode == LINE_HIGH);
            push_tick(rq);
        end
    endtask

    // Mostly whole transfers with random content; the rest is a noise burst
    task automatic random_step();
        int          pick;
        logic [12:0] addr;

        pick = $urandom_range(99);
        if (pick < 85)
        begin
            if ($urandom_range(9) == 0)
                addr = $urandom_range(1) ? 13'h1FFF : 13'h0000;
            else
                addr = 13'($urandom_range(8191));
            run_transfer(1'($urandom_range(1)), addr, 8'($urandom_range(255)), LINE_RANDOM);
            // zero idle ticks gives back-to-back transfers
            run_idle($urandom_range(3));
        end
        else
        begin
            for (int i = 0; i < $urandom_range(6, 1); i++)
                push_tick(noise_tick(1'($urandom_range(1))));
        end
    endtask

    // Timeout on a stuck handshake
    initial
    begin
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence
    initial
    begin
        int stop_at;

        sb = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        ticks_sent = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, both operations, back-to-back, line levels
        run_idle(3);
        run_transfer(OP_WRITE, 13'h0000, 8'h00, LINE_LOW);
        run_transfer(OP_WRITE, 13'h1FFF, 8'hFF, LINE_HIGH);
        run_transfer(OP_READ,  13'h1FFF, 8'hFF, LINE_HIGH);
        run_transfer(OP_READ,  13'h0000, 8'h00, LINE_LOW);
        run_idle(1);
        run_transfer(OP_WRITE, 13'h0AAA, 8'h55, LINE_RANDOM);
        run_transfer(OP_READ,  13'h1555, 8'hAA, LINE_RANDOM);
        run_idle(2);

        // Random: no idling, sender gaps, receiver stalls, light mix of both
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = (ph == 1) ? 65 : (ph == 3) ? 7 : 0;
            sink_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 7 : 0;
            // long output hold while requests keep coming
            if (ph == 0)
                hold_request = HOLD_CYCLES;
            stop_at = ticks_sent + PHASE_TICKS;
            while (ticks_sent < stop_at)
                random_step();
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d writes and %0d reads over %0d ticks, %0d starts ignored while busy.",
                 sb.writes_started, sb.reads_started, ticks_sent, sb.starts_ignored);
        $display("Checked %0d results across four idling mixes and one long output hold.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hdl/twspi_pkg.sv
hdl/twspi_if.sv
hdl/twspi_tick.sv
hdl/three_wire_spi_register_master_core.sv
hdl/twspi_core_checker.sv
dv/twspi_tb_pkg.sv
dv/tb.sv
